// ===== hw/rtl/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
package efr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [1:0] CFG_ESC_CODE    = 2'd1;
    localparam logic [1:0] CFG_CRC_POLY    = 2'd2;
    localparam logic [1:0] CFG_SENDER_MASK = 2'd3;

    localparam logic [7:0]  RST_START_BYTE  = 8'hFD;
    localparam logic [7:0]  RST_ESC_CODE    = 8'hFC;
    localparam logic [15:0] RST_CRC_POLY    = 16'h1002;
    localparam logic [7:0]  RST_SENDER_MASK = 8'h08;

    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [7:0]  ESC_BIT    = 8'h80;

    // Frame layout positions, as 9-bit values wide enough for any position.
    localparam logic [8:0] POS_CONTROL  = 9'd4;
    localparam logic [8:0] POS_LENGTH   = 9'd9;
    localparam logic [8:0] SENDER_BYTES = 9'd4;
    localparam logic [7:0] MIN_LENGTH   = 8'd2;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  esc_code;
        logic [15:0] crc_polynomial;
        logic [7:0]  sender_flag_mask;
    } t_cfg;

    typedef struct packed {
        logic        byte_stored;
        logic [6:0]  byte_index;
        logic [7:0]  byte_value;
        logic        frame_ok;
        logic        crc_error;
        logic        length_error;
        logic [31:0] target_address;
        logic [31:0] sender_address;
        logic [7:0]  control_value;
        logic [7:0]  payload_length;
    } t_result;

endpackage

// ===== hw/rtl/efr_crc16.sv =====
// Eight-bit unrolled update of the bit-serial CRC-16.
module efr_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_poly,
    output logic [15:0] o_crc
);
    always_comb begin
        logic [15:0] c;
        logic        top;
        c = i_crc;
        for (int k = 0; k < 8; k++) begin
            top = c[15];
            c   = {c[14:0], i_data[7 - k]};
            if (top) begin
                c = c ^ i_poly;
            end
        end
        o_crc = c;
    end
endmodule

// ===== hw/rtl/efr_parser.sv =====
// Frame state and the per-byte parsing step.
module efr_parser #(
    parameter int MAX_LENGTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  efr_pkg::t_cfg    i_cfg,
    output efr_pkg::t_result o_result
);
    import efr_pkg::*;

    localparam int POS_W = $clog2(MAX_LENGTH + 10);
    localparam logic [7:0] MAX_LEN8 = 8'(MAX_LENGTH);

    logic             r_in_frame, n_in_frame;
    logic             r_esc, n_esc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [31:0]      r_target, n_target;
    logic [31:0]      r_sender, n_sender;
    logic [7:0]       r_control, n_control;
    logic [7:0]       r_length, n_length;

    logic        is_esc, is_start;
    logic [7:0]  eb;
    logic [15:0] crc_in, crc_out;
    logic [8:0]  pos9;
    t_result     res;

    assign is_esc   = (i_byte == i_cfg.esc_code);
    assign is_start = !is_esc && (i_byte == i_cfg.start_byte);
    assign eb       = r_esc ? (i_byte | ESC_BIT) : i_byte;
    assign crc_in   = is_start ? CRC_SEED : r_crc;
    assign pos9     = 9'(r_pos);

    efr_crc16 u_crc (
        .i_crc  (crc_in),
        .i_data (is_start ? i_byte : eb),
        .i_poly (i_cfg.crc_polynomial),
        .o_crc  (crc_out)
    );

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_target   = r_target;
        n_sender   = r_sender;
        n_control  = r_control;
        n_length   = r_length;
        res        = '0;

        if (is_esc) begin
            n_esc = 1'b1;
        end else if (is_start) begin
            n_in_frame = 1'b1;
            n_esc      = 1'b0;
            n_pos      = '0;
            n_target   = '0;
            n_sender   = '0;
            n_control  = '0;
            n_length   = '0;
            n_crc      = crc_out;
        end else if (r_in_frame) begin
            n_esc            = 1'b0;
            n_crc            = crc_out;
            res.byte_stored  = 1'b1;
            res.byte_index   = pos9[6:0];
            res.byte_value   = eb;
            n_pos            = r_pos + POS_W'(1);
            if (pos9 < POS_CONTROL) begin
                n_target = {r_target[23:0], eb};
            end else if (pos9 == POS_CONTROL) begin
                n_control = eb;
                // Without the sender flag the four sender positions are skipped.
                if ((eb & i_cfg.sender_flag_mask) == 8'd0) begin
                    n_pos = POS_W'(pos9 + SENDER_BYTES + 9'd1);
                end
            end else if (pos9 < POS_LENGTH) begin
                n_sender = {r_sender[23:0], eb};
            end else if (pos9 == POS_LENGTH) begin
                n_length = eb;
                if (eb > MAX_LEN8 || eb < MIN_LENGTH) begin
                    n_in_frame       = 1'b0;
                    n_pos            = r_pos;
                    res.length_error = 1'b1;
                end
            end else if (pos9 == POS_LENGTH + {1'b0, r_length}) begin
                n_in_frame = 1'b0;
                n_pos      = r_pos;
                if (crc_out == 16'd0) begin
                    res.frame_ok       = 1'b1;
                    res.payload_length = r_length - MIN_LENGTH;
                end else begin
                    res.crc_error = 1'b1;
                end
            end
        end

        res.target_address = n_target;
        res.sender_address = n_sender;
        res.control_value  = n_control;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_pos      <= '0;
            r_crc      <= CRC_SEED;
            r_target   <= '0;
            r_sender   <= '0;
            r_control  <= '0;
            r_length   <= '0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_target   <= n_target;
            r_sender   <= n_sender;
            r_control  <= n_control;
            r_length   <= n_length;
        end
    end
endmodule

// ===== hw/rtl/escaped_frame_receiver_crc16_top.sv =====
// Top level of the escaped frame receiver: input register, parser and result register.
//
// Raw bus bytes enter on the input channel (i_valid/o_ready, i_rx_byte).
// Every accepted byte yields exactly one result transfer on the output
// channel (o_valid/i_ready): the stored byte and its frame index, the held
// header fields, and on the last byte of a frame either frame_ok with the
// payload length or crc_error; length_error flags a bad length byte.
// A byte is parsed and has its CRC updated while it sits in the input
// register and moves into the result register when that register is free
// or being emptied. One byte per cycle is sustained while i_ready stays
// high; the loop through the frame state and the unrolled 8-bit CRC sets
// that figure.
// When the receiver holds i_ready low, the result register keeps its value,
// the input register holds one more byte, and o_ready then drops.
// Reset (synchronous, i_rst_n low) empties both registers, leaves the parser
// outside a frame with the CRC at all ones, and restores the configuration
// defaults. Configuration writes (i_cfg_we) are registered in the configuration register.
module escaped_frame_receiver_crc16_top #(
    parameter int MAX_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_byte_stored,
    output logic [6:0]  o_byte_index,
    output logic [7:0]  o_byte_value,
    output logic        o_frame_ok,
    output logic        o_crc_error,
    output logic        o_length_error,
    output logic [31:0] o_target_address,
    output logic [31:0] o_sender_address,
    output logic [7:0]  o_control_value,
    output logic [7:0]  o_payload_length
);
    import efr_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    step;

    // The parsed byte moves on when the result register is free or being emptied.
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte       <= RST_START_BYTE;
            r_cfg.esc_code         <= RST_ESC_CODE;
            r_cfg.crc_polynomial   <= RST_CRC_POLY;
            r_cfg.sender_flag_mask <= RST_SENDER_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_BYTE:  r_cfg.start_byte       <= i_cfg_data[7:0];
                CFG_ESC_CODE:    r_cfg.esc_code         <= i_cfg_data[7:0];
                CFG_CRC_POLY:    r_cfg.crc_polynomial   <= i_cfg_data;
                CFG_SENDER_MASK: r_cfg.sender_flag_mask <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    efr_parser #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_stored    = r_out.byte_stored;
    assign o_byte_index     = r_out.byte_index;
    assign o_byte_value     = r_out.byte_value;
    assign o_frame_ok       = r_out.frame_ok;
    assign o_crc_error      = r_out.crc_error;
    assign o_length_error   = r_out.length_error;
    assign o_target_address = r_out.target_address;
    assign o_sender_address = r_out.sender_address;
    assign o_control_value  = r_out.control_value;
    assign o_payload_length = r_out.payload_length;

    // A frame ends in at most one way.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_ok && r_out.crc_error)
                        && !(r_out.frame_ok && r_out.length_error)
                        && !(r_out.crc_error && r_out.length_error))
        else $error("more than one frame outcome in one result");

    // Every frame outcome comes from a stored frame byte.
    a_outcome_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.frame_ok || r_out.crc_error || r_out.length_error)
        |-> r_out.byte_stored)
        else $error("frame outcome without a stored byte");

    // Without a stored byte the index and value read as zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.byte_stored
        |-> r_out.byte_index == 7'd0 && r_out.byte_value == 8'd0)
        else $error("index or value set without a stored byte");

    // A byte waiting behind a stalled result stays in the input register.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |=> r_in_valid && $stable(r_in_byte))
        else $error("input byte lost during a stall");

    // The result register takes a new item only once the previous one is gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> !r_out_valid || i_ready)
        else $error("result overwritten before transfer");
endmodule

// ===== test/escaped_frame_receiver_crc16_top_test.sv =====
// Self-checking testbench for the escaped frame receiver with CRC-16 check.
module escaped_frame_receiver_crc16_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    localparam int FRAME_MAX_LEN = 64;
    localparam int PHASE_ITEMS   = 185;
    localparam int STUCK_LIMIT   = 3000;
    localparam int DIR_ROWS      = 27;

    localparam t_result NO_RESULT = '0;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_START_BYTE;
    logic [15:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic        o_byte_stored;
    logic [6:0]  o_byte_index;
    logic [7:0]  o_byte_value;
    logic        o_frame_ok;
    logic        o_crc_error;
    logic        o_length_error;
    logic [31:0] o_target_address;
    logic [31:0] o_sender_address;
    logic [7:0]  o_control_value;
    logic [7:0]  o_payload_length;

    // Configuration as the block should currently hold it.
    t_cfg cfg_now = {RST_START_BYTE, RST_ESC_CODE, RST_CRC_POLY, RST_SENDER_MASK};

    // Receiver state tracked alongside the block.
    logic        fr_in_frame    = 1'b0;
    logic        fr_esc_pending = 1'b0;
    logic [8:0]  fr_pos         = '0;
    logic [15:0] fr_crc         = CRC_SEED;
    logic [31:0] fr_target      = '0;
    logic [31:0] fr_sender      = '0;
    logic [7:0]  fr_control     = '0;
    logic [7:0]  fr_length      = '0;

    t_result expect_q[$];
    int      error_count    = 0;
    int      items_in_phase = 0;
    int      stuck_cycles   = 0;
    bit      calm           = 1'b0;
    bit      use_typed      = 1'b0;
    t_result typed_want     = '0;

    // Directed bytes under the reset configuration. Rows with a typed
    // expectation are checked against it; the rest go through the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        {8'h00, 1'b1, NO_RESULT},
        {8'hFF, 1'b1, NO_RESULT},
        {8'hFC, 1'b1, NO_RESULT},
        {8'hFD, 1'b1, NO_RESULT},
        {8'hFF, 1'b1, {1'b1, 7'd0, 8'hFF, 3'b000, 32'h0000_00FF, 32'h0, 8'h00, 8'h00}},
        {8'h00, 1'b0, NO_RESULT},
        {8'hFC, 1'b0, NO_RESULT},
        {8'h7F, 1'b0, NO_RESULT},
        {8'h01, 1'b0, NO_RESULT},
        {8'h08, 1'b0, NO_RESULT},
        {8'h00, 1'b0, NO_RESULT},
        {8'h80, 1'b0, NO_RESULT},
        {8'hFC, 1'b0, NO_RESULT},
        {8'hFC, 1'b0, NO_RESULT},
        {8'h7E, 1'b0, NO_RESULT},
        {8'hFF, 1'b0, NO_RESULT},
        {8'h41, 1'b1, {1'b1, 7'd9, 8'h41, 3'b001, 32'hFF00_FF01, 32'h0080_FEFF, 8'h08, 8'h00}},
        {8'h12, 1'b0, NO_RESULT},
        {8'hFD, 1'b1, NO_RESULT},
        {8'hAA, 1'b0, NO_RESULT},
        {8'hFD, 1'b1, NO_RESULT},
        {8'h01, 1'b0, NO_RESULT},
        {8'h02, 1'b0, NO_RESULT},
        {8'h03, 1'b0, NO_RESULT},
        {8'h04, 1'b0, NO_RESULT},
        {8'hF7, 1'b0, NO_RESULT},
        {8'h01, 1'b1, {1'b1, 7'd9, 8'h01, 3'b001, 32'h0102_0304, 32'h0, 8'hF7, 8'h00}}
    };

    escaped_frame_receiver_crc16_top #(
        .MAX_LENGTH(FRAME_MAX_LEN)
    ) i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic top;
        for (int k = 7; k >= 0; k--) begin
            top = crc[15];
            crc = {crc[14:0], b[k]};
            if (top) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

    // Advances the tracked receiver state by one bus byte and returns the
    // result the block should give for it.
    function automatic t_result frame_predict(input logic [7:0] raw);
        logic [7:0] b;
        logic       advance;
        t_result    res;
        res = '0;
        b = raw;
        if (b == cfg_now.esc_code) begin
            fr_esc_pending = 1'b1;
        end else if (b == cfg_now.start_byte) begin
            fr_in_frame    = 1'b1;
            fr_esc_pending = 1'b0;
            fr_pos         = '0;
            fr_target      = '0;
            fr_sender      = '0;
            fr_control     = '0;
            fr_length      = '0;
            fr_crc         = crc16_feed(CRC_SEED, b, cfg_now.crc_polynomial);
        end else if (fr_in_frame) begin
            advance = 1'b1;
            if (fr_esc_pending) begin
                b = b | ESC_BIT;
                fr_esc_pending = 1'b0;
            end
            fr_crc = crc16_feed(fr_crc, b, cfg_now.crc_polynomial);
            res.byte_stored = 1'b1;
            res.byte_index  = fr_pos[6:0];
            res.byte_value  = b;
            if (fr_pos < POS_CONTROL) begin
                fr_target = {fr_target[23:0], b};
            end else if (fr_pos == POS_CONTROL) begin
                fr_control = b;
                // Without the sender flag the layout skips the sender address.
                if ((b & cfg_now.sender_flag_mask) == 8'h00) begin
                    fr_pos = fr_pos + SENDER_BYTES;
                end
            end else if (fr_pos < POS_LENGTH) begin
                fr_sender = {fr_sender[23:0], b};
            end else if (fr_pos == POS_LENGTH) begin
                fr_length = b;
                if (b > FRAME_MAX_LEN || b < MIN_LENGTH) begin
                    fr_in_frame = 1'b0;
                    res.length_error = 1'b1;
                    advance = 1'b0;
                end
            end else if (fr_pos == POS_LENGTH + fr_length) begin
                fr_in_frame = 1'b0;
                advance = 1'b0;
                if (fr_crc == 16'h0000) begin
                    res.frame_ok = 1'b1;
                    res.payload_length = fr_length - MIN_LENGTH;
                end else begin
                    res.crc_error = 1'b1;
                end
            end
            if (advance) begin
                fr_pos = fr_pos + 9'd1;
            end
        end
        res.target_address = fr_target;
        res.sender_address = fr_sender;
        res.control_value  = fr_control;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_result(input t_result got, input t_result want);
        if (got.byte_stored !== want.byte_stored)
            report_error($sformatf("byte_stored %0h, expected %0h",
                                   got.byte_stored, want.byte_stored));
        if (got.byte_index !== want.byte_index)
            report_error($sformatf("byte_index %0d, expected %0d",
                                   got.byte_index, want.byte_index));
        if (got.byte_value !== want.byte_value)
            report_error($sformatf("byte_value %h, expected %h",
                                   got.byte_value, want.byte_value));
        if (got.frame_ok !== want.frame_ok)
            report_error($sformatf("frame_ok %0h, expected %0h", got.frame_ok, want.frame_ok));
        if (got.crc_error !== want.crc_error)
            report_error($sformatf("crc_error %0h, expected %0h",
                                   got.crc_error, want.crc_error));
        if (got.length_error !== want.length_error)
            report_error($sformatf("length_error %0h, expected %0h",
                                   got.length_error, want.length_error));
        if (got.target_address !== want.target_address)
            report_error($sformatf("target_address %h, expected %h",
                                   got.target_address, want.target_address));
        if (got.sender_address !== want.sender_address)
            report_error($sformatf("sender_address %h, expected %h",
                                   got.sender_address, want.sender_address));
        if (got.control_value !== want.control_value)
            report_error($sformatf("control_value %h, expected %h",
                                   got.control_value, want.control_value));
        if (got.payload_length !== want.payload_length)
            report_error($sformatf("payload_length %0d, expected %0d",
                                   got.payload_length, want.payload_length));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 12);
        else return $urandom_range(20, 45);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(2, 10);
        else if (r < 92) return $urandom_range(11, 40);
        else if (r < 96) return $urandom_range(41, FRAME_MAX_LEN - 1);
        else return FRAME_MAX_LEN;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return cfg_now.start_byte;
            1: return cfg_now.esc_code;
            default: return 8'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Sends a frame byte, escaping it where it collides with a control value and now and then
    // otherwise, but only if its top bit is set and its low bits match neither control value.
    task automatic put_stuffed(input logic [7:0] v);
        logic [7:0] low;
        logic       special;
        low = v & ~ESC_BIT;
        special = (v == cfg_now.start_byte) || (v == cfg_now.esc_code);
        if ((special || $urandom_range(0, 3) == 0) && v[7] &&
            low != cfg_now.start_byte && low != cfg_now.esc_code) begin
            put_byte(cfg_now.esc_code);
            put_byte(low);
        end else begin
            put_byte(v);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [15:0] poly;
        logic [7:0]  ctrl;
        int          kind;
        int          len;
        int          n;
        poly = cfg_now.crc_polynomial;
        kind = $urandom_range(0, 99);
        calm = ($urandom_range(0, 99) < 12);
        if (kind < 10) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(noise_byte());
            return;
        end
        repeat (4) body.push_back(8'($urandom));
        ctrl = 8'($urandom);
        body.push_back(ctrl);
        if ((ctrl & cfg_now.sender_flag_mask) != 8'h00) begin
            repeat (4) body.push_back(8'($urandom));
        end
        if (kind < 16) begin
            case ($urandom_range(0, 2))
                0: len = 0;
                1: len = 1;
                default: len = $urandom_range(FRAME_MAX_LEN + 1, 255);
            endcase
            body.push_back(8'(len));
        end else begin
            len = pick_length();
            body.push_back(8'(len));
            repeat (len - 2) body.push_back(8'($urandom));
            crc = crc16_feed(CRC_SEED, cfg_now.start_byte, poly);
            foreach (body[i]) crc = crc16_feed(crc, body[i], poly);
            // Shifting two zero bytes through gives the check value that
            // leaves a zero residue once it is sent.
            crc = crc16_feed(crc16_feed(crc, 8'h00, poly), 8'h00, poly);
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
            if (kind < 24) begin
                n = $urandom_range(0, body.size() - 1);
                body[n] = body[n] ^ 8'(1 << $urandom_range(0, 7));
            end else if (kind < 32) begin
                n = $urandom_range(1, body.size() - 1);
                while (body.size() > n) void'(body.pop_back());
            end
        end
        put_byte(cfg_now.start_byte);
        foreach (body[i]) put_stuffed(body[i]);
    endtask

    task automatic set_config(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_data  <= {8'h00, c.start_byte};
        @(negedge i_clk);
        i_cfg_index <= CFG_ESC_CODE;
        i_cfg_data  <= {8'h00, c.esc_code};
        @(negedge i_clk);
        i_cfg_index <= CFG_CRC_POLY;
        i_cfg_data  <= c.crc_polynomial;
        @(negedge i_clk);
        i_cfg_index <= CFG_SENDER_MASK;
        i_cfg_data  <= {8'h00, c.sender_flag_mask};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_byte_stored, o_byte_index, o_byte_value, o_frame_ok, o_crc_error,
                       o_length_error, o_target_address, o_sender_address,
                       o_control_value, o_payload_length};
                if (expect_q.size() == 0) begin
                    report_error("result transfer with no byte outstanding");
                end else begin
                    check_result(got, expect_q.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                want = frame_predict(i_rx_byte);
                if (want.byte_stored || i_rx_byte == cfg_now.start_byte) begin
                    items_in_phase++;
                end
                if (use_typed) begin
                    want = typed_want;
                end
                expect_q.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("escaped_frame_receiver_crc16_top_test failed");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                stall = calm ? 0 : pick_gap();
            end
        end
    end

    initial begin
        t_cfg phase_cfg [6];
        phase_cfg = '{
            {8'hFD, 8'hFC, 16'h1002, 8'h08},
            {8'h00, 8'hFF, 16'hFFFF, 8'hFF},
            {8'hFF, 8'h80, 16'h0000, 8'h00},
            {8'h7E, 8'h00, 16'h8005, 8'h80},
            {8'h00, 8'h00, 16'h0000, 8'h00},
            {8'h55, 8'hAA, 16'h1021, 8'h01}
        };
        phase_cfg[4].start_byte       = 8'($urandom);
        phase_cfg[4].crc_polynomial   = 16'($urandom);
        phase_cfg[4].sender_flag_mask = 8'($urandom);
        do phase_cfg[4].esc_code = 8'($urandom);
        while (phase_cfg[4].esc_code == phase_cfg[4].start_byte);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            use_typed  = dir_rows[r].typed;
            typed_want = dir_rows[r].want;
            put_byte(dir_rows[r].rx);
        end
        use_typed = 1'b0;

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            set_config(phase_cfg[p]);
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) send_random_frame();
        end

        // With start and escape equal, the escape check wins and no frame opens.
        wait_idle();
        set_config({8'h5A, 8'h5A, 16'h1021, 8'h08});
        calm = 1'b0;
        repeat (24) put_byte(noise_byte());

        i_valid <= 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expect_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expect_q.size()));
        end
        if (error_count == 0) begin
            $display("escaped_frame_receiver_crc16_top_test passed");
        end else begin
            $display("escaped_frame_receiver_crc16_top_test failed");
        end
        $finish;
    end

endmodule
